/* design/ibst_pkg.sv */
// ----------------------------------------------------------------------------
// ibst_pkg
// shared types and constants of the implicit binary search tree key table
// ----------------------------------------------------------------------------
package ibst_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int OP_W         = 2;
    localparam int KEY_W        = 32;
    localparam int OUTCOME_W    = 2;
    localparam int CNT_W        = 11;
    localparam int SUM_W        = 42;
    localparam int S_DATA_W     = 40;
    localparam int M_DATA_W     = 56;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef enum logic [OUTCOME_W-1:0] {
        OUT_INSERTED  = 2'd0,
        OUT_DUPLICATE = 2'd1,
        OUT_NO_ROOM   = 2'd2,
        OUT_OTHER     = 2'd3
    } t_outcome;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_READ,
        S_CMP,
        S_CLR,
        S_DONE
    } t_state;

    typedef struct packed {
        logic     load_in;
        logic     rd;
        logic     step;
        logic     wr;
        logic     clr_start;
        logic     clr_step;
        logic     out_load;
        t_outcome outcome;
        logic     found;
    } t_cmd;

    typedef struct packed {
        logic idx_out;
        logic empty;
        logic hit;
        logic clr_last;
        logic out_free;
    } t_stat;

endpackage

/* design/ibst_ctrl.sv */
// ----------------------------------------------------------------------------
// ibst_ctrl
// sequencer for the tree walk, the insert commit and the clearing sweep
// ----------------------------------------------------------------------------
module ibst_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  ibst_pkg::t_op    i_op,
    output logic             o_s_tready,
    input  ibst_pkg::t_stat  i_stat,
    output ibst_pkg::t_cmd   o_cmd
);

    ibst_pkg::t_state   r_state, n_state;
    logic               r_is_ins, n_is_ins;
    ibst_pkg::t_outcome r_outcome, n_outcome;
    logic               r_found, n_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ibst_pkg::S_INIT;
            r_is_ins  <= 1'b0;
            r_outcome <= ibst_pkg::OUT_OTHER;
            r_found   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_is_ins  <= n_is_ins;
            r_outcome <= n_outcome;
            r_found   <= n_found;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_is_ins   = r_is_ins;
        n_outcome  = r_outcome;
        n_found    = r_found;
        o_s_tready = 1'b0;
        o_cmd      = '0;
        o_cmd.outcome = r_outcome;
        o_cmd.found   = r_found;
        case (r_state)
            ibst_pkg::S_INIT: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ibst_pkg::S_IDLE;
                end
            end
            ibst_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_is_ins  = (i_op == ibst_pkg::OP_INSERT);
                    n_outcome = ibst_pkg::OUT_OTHER;
                    n_found   = 1'b0;
                    case (i_op)
                        ibst_pkg::OP_INSERT,
                        ibst_pkg::OP_SEARCH: begin
                            n_state = ibst_pkg::S_READ;
                        end
                        ibst_pkg::OP_CLEAR: begin
                            o_cmd.clr_start = 1'b1;
                            n_state = ibst_pkg::S_CLR;
                        end
                        default: begin
                            n_state = ibst_pkg::S_DONE;
                        end
                    endcase
                end
            end
            ibst_pkg::S_READ: begin
                if (i_stat.idx_out) begin
                    if (r_is_ins) begin
                        n_outcome = ibst_pkg::OUT_NO_ROOM;
                    end
                    n_state = ibst_pkg::S_DONE;
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = ibst_pkg::S_CMP;
                end
            end
            ibst_pkg::S_CMP: begin
                if (i_stat.empty) begin
                    if (r_is_ins) begin
                        o_cmd.wr  = 1'b1;
                        n_outcome = ibst_pkg::OUT_INSERTED;
                    end
                    n_state = ibst_pkg::S_DONE;
                end else if (i_stat.hit) begin
                    if (r_is_ins) begin
                        n_outcome = ibst_pkg::OUT_DUPLICATE;
                    end else begin
                        n_found = 1'b1;
                    end
                    n_state = ibst_pkg::S_DONE;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = ibst_pkg::S_READ;
                end
            end
            ibst_pkg::S_CLR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ibst_pkg::S_DONE;
                end
            end
            ibst_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = ibst_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = ibst_pkg::S_INIT;
            end
        endcase
    end

endmodule

/* design/ibst_dp.sv */
// ----------------------------------------------------------------------------
// ibst_dp
// slot memory, walk index, key compare, count and sum, result register
// ----------------------------------------------------------------------------
module ibst_dp #(
    parameter int CAPACITY = ibst_pkg::CAPACITY_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic signed [ibst_pkg::KEY_W-1:0]   i_key,
    input  ibst_pkg::t_cmd                      i_cmd,
    output ibst_pkg::t_stat                     o_stat,
    input  logic                                i_m_tready,
    output logic                                o_m_tvalid,
    output logic [ibst_pkg::M_DATA_W-1:0]       o_m_tdata
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int WW = AW + 2;
    localparam int KW = ibst_pkg::KEY_W;

    // entry layout: valid bit above the key
    logic [KW:0]                           mem [CAPACITY];
    logic [KW:0]                           r_rdata;
    logic signed [KW-1:0]                  r_key;
    logic [WW-1:0]                         r_idx;
    logic [ibst_pkg::CNT_W-1:0]            r_count;
    logic signed [ibst_pkg::SUM_W-1:0]     r_sum;
    logic                                  r_m_valid;
    logic [ibst_pkg::M_DATA_W-1:0]         r_m_data;
    logic signed [KW-1:0]                  node_key;
    logic                                  go_left;
    logic [WW-1:0]                         child_base;

    assign node_key   = r_rdata[KW-1:0];
    assign go_left    = r_key < node_key;
    assign child_base = {r_idx[WW-2:0], 1'b0};

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr || i_cmd.clr_step) begin
            mem[r_idx[AW-1:0]] <= {i_cmd.wr, r_key};
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[r_idx[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_key <= i_key;
        end
        if (i_cmd.out_load) begin
            r_m_data <= {r_sum, r_count, i_cmd.found, i_cmd.outcome};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_count   <= '0;
            r_sum     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (i_cmd.load_in || i_cmd.clr_start) begin
                r_idx <= '0;
            end else if (i_cmd.step) begin
                r_idx <= go_left ? child_base + WW'(1) : child_base + WW'(2);
            end else if (i_cmd.clr_step) begin
                r_idx <= r_idx + WW'(1);
            end
            if (i_cmd.clr_start) begin
                r_count <= '0;
                r_sum   <= '0;
            end else if (i_cmd.wr) begin
                r_count <= r_count + ibst_pkg::CNT_W'(1);
                r_sum   <= r_sum + ibst_pkg::SUM_W'(r_key);
            end
            if (i_cmd.out_load) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_comb begin
        o_stat.idx_out  = r_idx >= WW'(CAPACITY);
        o_stat.empty    = !r_rdata[KW];
        o_stat.hit      = node_key == r_key;
        o_stat.clr_last = r_idx == WW'(CAPACITY - 1);
        o_stat.out_free = !r_m_valid || i_m_tready;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

endmodule

/* design/implicit_bst_key_table_unit.sv */
// ----------------------------------------------------------------------------
// implicit_bst_key_table_unit
// Binary search tree of signed 32-bit keys in an implicit array layout: slot
// i has its children at 2i+1 and 2i+2. Insert walks from the root and fills
// the first empty slot (duplicates are ignored, a walk that leaves the table
// drops the key); search reports whether the key is present; clear empties
// the table. Each transaction returns one result with the entry count and
// the running key sum. Insert and search visit each tree level with the
// registered read of the single-port slot memory (S_READ) followed by the
// compare (S_CMP). Clear sweeps the slots in order, one slot a cycle. After
// reset a clearing pass over all slots runs before the first transaction is
// taken. A finished result waits in an output register while the next
// transaction is accepted.
// ----------------------------------------------------------------------------
module implicit_bst_key_table_unit #(
    parameter int CAPACITY = ibst_pkg::CAPACITY_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [ibst_pkg::S_DATA_W-1:0]     i_s_tdata,  // opcode, key
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [ibst_pkg::M_DATA_W-1:0]     o_m_tdata   // outcome, found, entry_count, key_sum
);

    ibst_pkg::t_cmd  cmd;
    ibst_pkg::t_stat stat;
    ibst_pkg::t_op   in_op;
    logic signed [ibst_pkg::KEY_W-1:0] in_key;

    assign in_op  = ibst_pkg::t_op'(i_s_tdata[ibst_pkg::OP_W-1:0]);
    assign in_key = i_s_tdata[ibst_pkg::OP_W +: ibst_pkg::KEY_W];

    ibst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_op       (in_op),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    ibst_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_key      (in_key),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata)
    );

endmodule

/* design/ibst_chk.sv */
// ----------------------------------------------------------------------------
// ibst_chk
// port-level checks of the key table, bound to the top level
// ----------------------------------------------------------------------------
module ibst_chk #(
    parameter int CAPACITY = ibst_pkg::CAPACITY_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_s_tvalid,
    input logic                              o_s_tready,
    input logic [ibst_pkg::S_DATA_W-1:0]     i_s_tdata,
    input logic                              o_m_tvalid,
    input logic                              i_m_tready,
    input logic [ibst_pkg::M_DATA_W-1:0]     o_m_tdata
);

    localparam int CNT_LO = ibst_pkg::OUTCOME_W + 1;

    // no result straight out of reset
    a_rst_no_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // clearing pass holds off input after reset
    a_rst_busy: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_tready)
        else $error("input taken during reset clearing pass");

    // one transaction at a time
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second transaction taken while busy");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // entry count never above capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (32'(o_m_tdata[CNT_LO +: ibst_pkg::CNT_W]) <= CAPACITY))
        else $error("entry count above capacity");

endmodule

bind implicit_bst_key_table_unit ibst_chk #(
    .CAPACITY (CAPACITY)
) u_ibst_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

/* verif/tb_implicit_bst_key_table_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_implicit_bst_key_table_unit
// Self-checking bench for the implicit binary search tree key table. A queue
// of insert, search and clear transactions (directed corner cases, then
// random runs that fill, overflow and clear the tree) feeds the slave side.
// An internal table model predicts outcome, found flag, entry count and key
// sum for every accepted transaction, and the master side is checked against
// it in order. Both sides throttle at random in the first two of three phases.
// ----------------------------------------------------------------------------
module tb_implicit_bst_key_table_unit;

    import ibst_pkg::*;

    localparam int                CAP        = CAPACITY_DEF;
    localparam logic [OP_W-1:0]   OP_UNUSED  = 2'd3;
    localparam int                NUM_REQS   = 1300;
    localparam int                QUIET_MAX  = 4000;
    localparam int                DRAIN_WAIT = 40;
    localparam int                MAX_PRINTS = 60;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [KEY_W-1:0] key;
    } t_table_req;

    typedef struct {
        t_outcome         outcome;
        logic             found;
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
    } t_table_resp;

    logic                i_clk      = 1'b0;
    logic                i_rst_n    = 1'b0;
    logic                i_s_tvalid = 1'b0;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata  = '0;   // opcode, key
    logic                o_m_tvalid;
    logic                i_m_tready = 1'b0;
    logic [M_DATA_W-1:0] o_m_tdata;         // outcome, found, entry_count, key_sum

    implicit_bst_key_table_unit #(
        .CAPACITY (CAP)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #2 i_clk = ~i_clk;

    // table model
    bit               slot_used [CAP];
    logic [KEY_W-1:0] slot_key  [CAP];
    logic [CNT_W-1:0] model_count = '0;
    logic [SUM_W-1:0] model_sum   = '0;

    t_table_req  req_q  [$];
    t_table_resp resp_q [$];
    logic [KEY_W-1:0] known_keys [$];

    t_table_req cur_req;
    int total_reqs   = 0;
    int sent_reqs    = 0;
    int phase        = 0;
    int calm_cycles  = 0;
    int quiet_cycles = 0;
    int mismatch_cnt = 0;

    function automatic t_table_resp table_apply(t_table_req req);
        t_table_resp resp;
        int unsigned idx;
        bit          hit;
        bit          done;
        resp.outcome = OUT_OTHER;
        resp.found   = 1'b0;
        idx  = 0;
        hit  = 1'b0;
        done = 1'b0;
        if (req.op == OP_INSERT || req.op == OP_SEARCH) begin
            while (!done && idx < CAP) begin
                if (!slot_used[idx]) begin
                    done = 1'b1;
                end else if (req.key == slot_key[idx]) begin
                    hit  = 1'b1;
                    done = 1'b1;
                end else begin
                    idx = ($signed(req.key) < $signed(slot_key[idx])) ? 2 * idx + 1
                                                                      : 2 * idx + 2;
                end
            end
        end
        if (req.op == OP_INSERT) begin
            if (hit) begin
                resp.outcome = OUT_DUPLICATE;
            end else if (idx >= CAP) begin
                resp.outcome = OUT_NO_ROOM;
            end else begin
                slot_used[idx] = 1'b1;
                slot_key[idx]  = req.key;
                model_count    = model_count + 1'b1;
                model_sum      = model_sum + {{(SUM_W - KEY_W){req.key[KEY_W-1]}}, req.key};
                resp.outcome   = OUT_INSERTED;
            end
        end else if (req.op == OP_SEARCH) begin
            resp.found = hit;
        end else if (req.op == OP_CLEAR) begin
            foreach (slot_used[i]) slot_used[i] = 1'b0;
            model_count = '0;
            model_sum   = '0;
        end
        resp.count = model_count;
        resp.sum   = model_sum;
        return resp;
    endfunction

    function automatic string resp_text(t_table_resp r);
        return $sformatf("outcome %0d found %0d count %0d sum %h",
                         r.outcome, r.found, r.count, r.sum);
    endfunction

    task automatic add_req(logic [OP_W-1:0] op, logic [KEY_W-1:0] key);
        t_table_req req;
        req.op  = op;
        req.key = key;
        req_q.push_back(req);
        if (op == OP_INSERT) begin
            known_keys.push_back(key);
        end else if (op == OP_CLEAR) begin
            known_keys.delete();
        end
    endtask

    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] k;
        case ($urandom_range(0, 9))
            0, 1:    k = $urandom_range(0, 40) - 20;
            2:       k = 32'h8000_0000 + $urandom_range(0, 7);
            3:       k = 32'h7fff_ffff - $urandom_range(0, 7);
            default: k = $urandom;
        endcase
        return k;
    endfunction

    function automatic logic [KEY_W-1:0] known_or_random();
        if (known_keys.size() == 0) return random_key();
        return known_keys[$urandom_range(0, known_keys.size() - 1)];
    endfunction

    task automatic fill_requests();
        int               run_len;
        int               style;
        int               roll;
        logic [KEY_W-1:0] base;
        logic [KEY_W-1:0] stride;
        bit               rising;
        // empty table, duplicates, extremes, unused opcode, path overflow
        add_req(OP_SEARCH, 32'h0000_0000);
        add_req(OP_INSERT, 32'h0000_0000);
        add_req(OP_INSERT, 32'h0000_0000);
        add_req(OP_INSERT, 32'h8000_0000);
        add_req(OP_INSERT, 32'h7fff_ffff);
        add_req(OP_SEARCH, 32'h8000_0000);
        add_req(OP_SEARCH, 32'h7fff_ffff);
        add_req(OP_SEARCH, 32'h0000_0005);
        add_req(OP_UNUSED, 32'hffff_ffff);
        add_req(OP_CLEAR,  32'hffff_ffff);
        for (int i = 1; i <= 11; i++) add_req(OP_INSERT, i);
        add_req(OP_SEARCH, 32'd11);
        add_req(OP_SEARCH, 32'd10);
        add_req(OP_CLEAR,  32'h0000_0000);

        while (req_q.size() < NUM_REQS) begin
            style = $urandom_range(0, 9);
            if ($urandom_range(0, 1) == 0) add_req(OP_CLEAR, $urandom);
            if (style < 7) begin
                run_len = $urandom_range(20, 80);
                for (int i = 0; i < run_len; i++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 50)      add_req(OP_INSERT, random_key());
                    else if (roll < 62) add_req(OP_INSERT, known_or_random());
                    else if (roll < 85) add_req(OP_SEARCH, known_or_random());
                    else if (roll < 96) add_req(OP_SEARCH, random_key());
                    else if (roll < 98) add_req(OP_UNUSED, $urandom);
                    else                add_req(OP_CLEAR, $urandom);
                end
            end else if (style < 9) begin
                // monotonic run walks one edge of the tree until it leaves the table
                if ($urandom_range(0, 9) < 7) add_req(OP_CLEAR, $urandom);
                rising = 1'($urandom_range(0, 1));
                stride = $urandom_range(1, 1000);
                base   = rising ? 32'hffff_0000 + $urandom_range(0, 4000)
                                : 32'h0001_0000 - $urandom_range(0, 4000);
                for (int i = 0; i < $urandom_range(11, 14); i++) begin
                    add_req(OP_INSERT, rising ? base + i * stride : base - i * stride);
                end
                for (int i = 0; i < 4; i++) add_req(OP_SEARCH, known_or_random());
            end else begin
                run_len = $urandom_range(20, 40);
                for (int i = 0; i < run_len; i++) begin
                    add_req($urandom_range(0, 2) == 0 ? OP_SEARCH : OP_INSERT,
                            $urandom_range(0, 15) - 8);
                end
            end
        end
    endtask

    function automatic int send_idle_pct(int ph);
        return (ph == 0) ? 7 : (ph == 1) ? 51 : 0;
    endfunction

    function automatic int recv_idle_pct(int ph);
        return (ph == 0) ? 51 : (ph == 1) ? 7 : 0;
    endfunction

    // driver
    always @(posedge i_clk) begin : drive_p
        bit idle;
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else begin
            if (i_s_tvalid && o_s_tready) begin
                resp_q.push_back(table_apply(cur_req));
                sent_reqs++;
            end
            if (total_reqs > 0) phase <= (sent_reqs * 3) / total_reqs;
            if (calm_cycles > 0) begin
                calm_cycles <= calm_cycles - 1;
            end else if ($urandom_range(0, 99) < 2) begin
                calm_cycles <= $urandom_range(20, 60);
            end
            if (!i_s_tvalid || o_s_tready) begin
                idle = (calm_cycles == 0) && ($urandom_range(0, 99) < send_idle_pct(phase));
                if (!idle && req_q.size() > 0) begin
                    cur_req = req_q.pop_front();
                    i_s_tdata  <= {{(S_DATA_W - KEY_W - OP_W){1'b0}}, cur_req.key, cur_req.op};
                    i_s_tvalid <= 1'b1;
                end else begin
                    i_s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin : check_p
        t_table_resp want;
        t_table_resp got;
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                got.outcome = t_outcome'(o_m_tdata[OUTCOME_W-1:0]);
                got.found   = o_m_tdata[OUTCOME_W];
                got.count   = o_m_tdata[OUTCOME_W+1 +: CNT_W];
                got.sum     = o_m_tdata[OUTCOME_W+1+CNT_W +: SUM_W];
                if (resp_q.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MAX_PRINTS)
                        $display("%0t: unexpected result, expected none, actual %h", $time,
                                 o_m_tdata);
                end else begin
                    want = resp_q.pop_front();
                    if (got.outcome !== want.outcome || got.found !== want.found ||
                        got.count !== want.count || got.sum !== want.sum) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= MAX_PRINTS)
                            $display("%0t: expected %s, actual %s",
                                     $time, resp_text(want), resp_text(got));
                    end
                end
            end
            i_m_tready <= !((calm_cycles == 0) && ($urandom_range(0, 99) < recv_idle_pct(phase)));
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_MAX) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        fill_requests();
        total_reqs = req_q.size();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        do @(negedge i_clk);
        while (req_q.size() > 0 || i_s_tvalid || resp_q.size() > 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        if (mismatch_cnt == 0 && resp_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* implicit_bst_key_table_unit.f */
design/ibst_pkg.sv
design/ibst_ctrl.sv
design/ibst_dp.sv
design/implicit_bst_key_table_unit.sv
design/ibst_chk.sv
verif/tb_implicit_bst_key_table_unit.sv
